### design/slt_pkg.sv
// Shared constants, types and helper functions for the script lexer tokenizer.
// Used by slt_scan, slt_queue and script_lexer_tokenizer. No dependencies.
`default_nettype none

package slt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 20;
    localparam int KEYWORD_MAX_DEF = 7;

    localparam int KIND_W  = 6;
    localparam int ERR_W   = 2;
    localparam int MAX_TOK = 3;   // tokens one source byte can produce
    localparam int CNT_W   = 2;   // holds 0..MAX_TOK
    localparam int Q_DEPTH = 8;
    localparam int KW_NUM  = 20;
    localparam int KW_BYTES = 7;  // longest keyword

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [ERR_W-1:0]  err_t;

    localparam err_t ERR_NONE       = 2'd0;
    localparam err_t ERR_UNEXPECTED = 2'd1;
    localparam err_t ERR_UNTERM     = 2'd2;

    localparam kind_t K_EOF       = 6'd0;
    localparam kind_t K_ERROR     = 6'd1;
    localparam kind_t K_IDENT     = 6'd2;
    localparam kind_t K_STRING    = 6'd3;
    localparam kind_t K_NUMBER    = 6'd4;
    localparam kind_t K_KEYWORD0  = 6'd5;
    localparam kind_t K_LPAREN    = 6'd25;
    localparam kind_t K_RPAREN    = 6'd26;
    localparam kind_t K_LBRACE    = 6'd27;
    localparam kind_t K_RBRACE    = 6'd28;
    localparam kind_t K_LBRACKET  = 6'd29;
    localparam kind_t K_RBRACKET  = 6'd30;
    localparam kind_t K_SEMI      = 6'd31;
    localparam kind_t K_COMMA     = 6'd32;
    localparam kind_t K_COLON     = 6'd33;
    localparam kind_t K_DOT       = 6'd34;
    localparam kind_t K_DOT_DOT   = 6'd35;
    localparam kind_t K_MINUS     = 6'd36;
    localparam kind_t K_MINUS2    = 6'd37;
    localparam kind_t K_MINUS_EQ  = 6'd38;
    localparam kind_t K_PLUS      = 6'd39;
    localparam kind_t K_PLUS2     = 6'd40;
    localparam kind_t K_PLUS_EQ   = 6'd41;
    localparam kind_t K_SLASH     = 6'd42;
    localparam kind_t K_SLASH_EQ  = 6'd43;
    localparam kind_t K_STAR      = 6'd44;
    localparam kind_t K_STAR_EQ   = 6'd45;
    localparam kind_t K_PERCENT   = 6'd46;
    localparam kind_t K_PCT_EQ    = 6'd47;
    localparam kind_t K_BANG      = 6'd48;
    localparam kind_t K_BANG_EQ   = 6'd49;
    localparam kind_t K_EQUAL     = 6'd50;
    localparam kind_t K_EQ_EQ     = 6'd51;
    localparam kind_t K_ARROW     = 6'd52;
    localparam kind_t K_LESS      = 6'd53;
    localparam kind_t K_LESS_EQ   = 6'd54;
    localparam kind_t K_GREATER   = 6'd55;
    localparam kind_t K_GT_EQ     = 6'd56;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_BANG  = 8'h21;

    typedef enum logic [8:0] {
        MODE_IDLE     = 9'b000000001,
        MODE_IDENT    = 9'b000000010,
        MODE_NUM_INT  = 9'b000000100,
        MODE_NUM_DOT  = 9'b000001000,
        MODE_NUM_FRAC = 9'b000010000,
        MODE_STRING   = 9'b000100000,
        MODE_SLASH    = 9'b001000000,
        MODE_COMMENT  = 9'b010000000,
        MODE_OP1      = 9'b100000000
    } scan_mode_t;

    // Keyword text, right aligned: first character in the highest used byte.
    localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_NUM] = '{
        56'("and"), 56'("class"), 56'("const"), 56'("else"), 56'("false"),
        56'("for"), 56'("fn"), 56'("if"), 56'("in"), 56'("init"),
        56'("include"), 56'("null"), 56'("new"), 56'("or"), 56'("private"),
        56'("return"), 56'("this"), 56'("true"), 56'("var"), 56'("while")
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd3, 3'd2, 3'd2, 3'd2, 3'd4,
        3'd7, 3'd4, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd4, 3'd3, 3'd5
    };

    function automatic logic ident_head(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic dec_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Word of 1..7 bytes against the keyword table; identifier if none match.
    function automatic kind_t kw_lookup(input logic [KW_BYTES-1:0][7:0] w,
                                        input logic [2:0] len);
        kind_t k;
        logic  m;
        k = K_IDENT;
        for (int i = 0; i < KW_NUM; i++) begin
            m = (len == KW_LEN[i]);
            for (int j = 0; j < KW_BYTES; j++) begin
                if (m && j < int'(KW_LEN[i])) begin
                    if (w[j] != KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j)*8 +: 8])
                        m = 1'b0;
                end
            end
            if (m)
                k = K_KEYWORD0 + kind_t'(i);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### design/slt_scan.sv
// Scanner core: state registers and the single-pass logic that turns one
// source byte into up to three tokens. Depends on slt_pkg.
`default_nettype none

module slt_scan
    import slt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [7:0]             ch,
    output kind_t                       tok_kind  [MAX_TOK],
    output logic [OFFSET_BITS-1:0]      tok_start [MAX_TOK],
    output logic [OFFSET_BITS-1:0]      tok_len   [MAX_TOK],
    output err_t                        tok_err   [MAX_TOK],
    output logic [LINE_BITS-1:0]        tok_line,
    output logic [CNT_W-1:0]            tok_count
);

    localparam int KI_W = (KEYWORD_MAX > 1) ? $clog2(KEYWORD_MAX) : 1;
    localparam logic [OFFSET_BITS-1:0] OFF_CAP  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_CAP = {LINE_BITS{1'b1}};

    scan_mode_t               mode_reg, mode_next;
    logic [7:0]               pend_reg, pend_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [OFFSET_BITS-1:0]   wlen_reg, wlen_next;
    logic [7:0]               wbuf_reg [KEYWORD_MAX];

    logic                     wr_en;
    logic [KI_W-1:0]          wr_idx;
    logic [KW_BYTES-1:0][7:0] kw_word;
    kind_t                    word_kind;
    logic                     redo_op;
    logic                     redo_idle;
    logic                     ended;
    logic                     took;
    kind_t                    op_k;
    logic [CNT_W-1:0]         n;

    always_comb
    begin
        for (int j = 0; j < KW_BYTES; j++)
            kw_word[j] = wbuf_reg[j];
        if (wlen_reg > OFFSET_BITS'(KW_BYTES) || wlen_reg == '0)
            word_kind = K_IDENT;
        else
            word_kind = kw_lookup(kw_word, wlen_reg[2:0]);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        start_next  = start_reg;
        wlen_next   = wlen_reg;
        line_next   = line_reg;
        offset_next = offset_reg;
        wr_en       = 1'b0;
        wr_idx      = wlen_reg[KI_W-1:0];
        redo_op     = 1'b0;
        redo_idle   = 1'b0;
        ended       = 1'b0;
        took        = 1'b0;
        op_k        = K_GREATER;
        n           = '0;
        for (int i = 0; i < MAX_TOK; i++)
        begin
            tok_kind[i]  = K_EOF;
            tok_start[i] = '0;
            tok_len[i]   = '0;
            tok_err[i]   = ERR_NONE;
        end

        // first pass: the mode left by the previous byte
        case (mode_reg)
            MODE_IDENT:
            begin
                if (ident_head(ch) || dec_numeral(ch))
                begin
                    if (wlen_reg < OFFSET_BITS'(KEYWORD_MAX))
                        wr_en = 1'b1;
                    if (wlen_next != OFF_CAP)
                        wlen_next = wlen_next + 1'b1;
                end
                else
                begin
                    tok_kind[n] = word_kind; tok_start[n] = start_reg;
                    tok_len[n] = wlen_reg; n = n + 1'b1;
                    redo_idle = 1'b1;
                end
            end
            MODE_NUM_INT, MODE_NUM_FRAC:
            begin
                if (dec_numeral(ch))
                begin
                    if (wlen_next != OFF_CAP)
                        wlen_next = wlen_next + 1'b1;
                end
                else if (ch == CH_DOT && mode_reg == MODE_NUM_INT)
                    mode_next = MODE_NUM_DOT;
                else
                begin
                    tok_kind[n] = K_NUMBER; tok_start[n] = start_reg;
                    tok_len[n] = wlen_reg; n = n + 1'b1;
                    redo_idle = 1'b1;
                end
            end
            MODE_NUM_DOT:
            begin
                if (dec_numeral(ch))
                begin
                    if (wlen_next != OFF_CAP)
                        wlen_next = wlen_next + 1'b1;
                    if (wlen_next != OFF_CAP)
                        wlen_next = wlen_next + 1'b1;
                    mode_next = MODE_NUM_FRAC;
                end
                else
                begin
                    tok_kind[n] = K_NUMBER; tok_start[n] = start_reg;
                    tok_len[n] = wlen_reg; n = n + 1'b1;
                    // rescan the dot as an operator that began one byte back
                    start_next = (offset_reg != '0) ? offset_reg - 1'b1 : '0;
                    wlen_next  = OFFSET_BITS'(1);
                    pend_next  = CH_DOT;
                    redo_op    = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (ch == CH_QUOTE)
                begin
                    if (wlen_next != OFF_CAP)
                        wlen_next = wlen_next + 1'b1;
                    tok_kind[n] = K_STRING; tok_start[n] = start_reg;
                    tok_len[n] = wlen_next; n = n + 1'b1;
                    mode_next = MODE_IDLE;
                end
                else if (ch == CH_NUL)
                begin
                    tok_kind[n] = K_ERROR; tok_start[n] = start_reg;
                    tok_len[n] = wlen_reg; tok_err[n] = ERR_UNTERM; n = n + 1'b1;
                    redo_idle = 1'b1;
                end
                else
                begin
                    if (ch == CH_LF && line_next != LINE_CAP)
                        line_next = line_next + 1'b1;
                    if (wlen_next != OFF_CAP)
                        wlen_next = wlen_next + 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (ch == CH_SLASH)
                    mode_next = MODE_COMMENT;
                else if (ch == CH_EQ)
                begin
                    tok_kind[n] = K_SLASH_EQ; tok_start[n] = start_reg;
                    tok_len[n] = OFFSET_BITS'(2); n = n + 1'b1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    tok_kind[n] = K_SLASH; tok_start[n] = start_reg;
                    tok_len[n] = OFFSET_BITS'(1); n = n + 1'b1;
                    redo_idle = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (ch == CH_LF || ch == CH_NUL)
                    redo_idle = 1'b1;
            end
            MODE_OP1:
                redo_op = 1'b1;
            default:
                redo_idle = 1'b1;
        endcase

        // second pass: resolve a pending one- or two-byte operator
        if (redo_op)
        begin
            case (pend_next)
                CH_DOT:
                begin
                    op_k = K_DOT;
                    if (ch == CH_DOT) begin took = 1'b1; op_k = K_DOT_DOT; end
                end
                CH_MINUS:
                begin
                    op_k = K_MINUS;
                    if (ch == CH_MINUS) begin took = 1'b1; op_k = K_MINUS2; end
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_MINUS_EQ; end
                end
                CH_PLUS:
                begin
                    op_k = K_PLUS;
                    if (ch == CH_PLUS) begin took = 1'b1; op_k = K_PLUS2; end
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_PLUS_EQ; end
                end
                CH_EQ:
                begin
                    op_k = K_EQUAL;
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_EQ_EQ; end
                    if (ch == CH_GT) begin took = 1'b1; op_k = K_ARROW; end
                end
                CH_STAR:
                begin
                    op_k = K_STAR;
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_STAR_EQ; end
                end
                CH_PCT:
                begin
                    op_k = K_PERCENT;
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_PCT_EQ; end
                end
                CH_BANG:
                begin
                    op_k = K_BANG;
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_BANG_EQ; end
                end
                CH_LT:
                begin
                    op_k = K_LESS;
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_LESS_EQ; end
                end
                default:
                begin
                    op_k = K_GREATER;
                    if (ch == CH_EQ) begin took = 1'b1; op_k = K_GT_EQ; end
                end
            endcase
            mode_next = MODE_IDLE;
            tok_kind[n]  = op_k;
            tok_start[n] = start_next;
            tok_len[n]   = took ? OFFSET_BITS'(2) : OFFSET_BITS'(1);
            n = n + 1'b1;
            if (!took)
                redo_idle = 1'b1;
        end

        // third pass: the byte seen between tokens
        if (redo_idle)
        begin
            mode_next  = MODE_IDLE;
            start_next = offset_reg;
            wlen_next  = OFFSET_BITS'(1);
            wr_idx     = '0;
            if (ch == CH_NUL)
            begin
                tok_kind[n] = K_EOF; tok_start[n] = offset_reg;
                tok_len[n] = '0; n = n + 1'b1;
                ended = 1'b1;
            end
            else if (ch == CH_SPACE || ch == CH_CR || ch == CH_TAB)
                mode_next = MODE_IDLE;
            else if (ch == CH_LF)
            begin
                if (line_next != LINE_CAP)
                    line_next = line_next + 1'b1;
            end
            else if (ch == CH_SLASH)
                mode_next = MODE_SLASH;
            else if (ident_head(ch))
            begin
                wr_en     = 1'b1;
                mode_next = MODE_IDENT;
            end
            else if (dec_numeral(ch))
                mode_next = MODE_NUM_INT;
            else if (ch == CH_QUOTE)
                mode_next = MODE_STRING;
            else if (ch == CH_DOT || ch == CH_MINUS || ch == CH_PLUS || ch == CH_STAR
                     || ch == CH_PCT || ch == CH_BANG || ch == CH_EQ || ch == CH_LT
                     || ch == CH_GT)
            begin
                pend_next = ch;
                mode_next = MODE_OP1;
            end
            else
            begin
                tok_start[n] = offset_reg;
                tok_len[n]   = OFFSET_BITS'(1);
                case (ch)
                    CH_LPAR:  tok_kind[n] = K_LPAREN;
                    CH_RPAR:  tok_kind[n] = K_RPAREN;
                    CH_LBRC:  tok_kind[n] = K_LBRACE;
                    CH_RBRC:  tok_kind[n] = K_RBRACE;
                    CH_LBRK:  tok_kind[n] = K_LBRACKET;
                    CH_RBRK:  tok_kind[n] = K_RBRACKET;
                    CH_SEMI:  tok_kind[n] = K_SEMI;
                    CH_COMMA: tok_kind[n] = K_COMMA;
                    CH_COLON: tok_kind[n] = K_COLON;
                    default:
                    begin
                        tok_kind[n] = K_ERROR;
                        tok_err[n]  = ERR_UNEXPECTED;
                    end
                endcase
                n = n + 1'b1;
            end
        end

        // restart for a new source after end of source
        if (ended)
        begin
            mode_next   = MODE_IDLE;
            offset_next = '0;
            line_next   = LINE_BITS'(1);
        end
        else if (offset_reg != OFF_CAP)
            offset_next = offset_reg + 1'b1;
    end

    assign tok_count = n;
    assign tok_line  = line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= '0;
            start_reg  <= '0;
            offset_reg <= '0;
            line_reg   <= LINE_BITS'(1);
            wlen_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            start_reg  <= start_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
            wlen_reg   <= wlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
            wbuf_reg[wr_idx] <= ch;
    end

endmodule

`default_nettype wire

### design/slt_queue.sv
// Token queue: takes up to three tokens a cycle, hands out one a cycle while pop is high.
// Depends on slt_pkg.
`default_nettype none

module slt_queue
    import slt_pkg::*;
#(
    parameter int W     = 77,
    parameter int DEPTH = Q_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [CNT_W-1:0]           push_count,
    input  wire logic [W-1:0]               push_data [MAX_TOK],
    input  wire logic                       pop,
    output logic [W-1:0]                    head,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH+1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LVL_W'(push_count) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TOK; i++)
        begin
            if (CNT_W'(i) < push_count)
                mem[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign level = level_reg;

endmodule

`default_nettype wire

### design/script_lexer_tokenizer.sv
// Top level of the script lexer tokenizer: scanner core feeding a token queue.
// Depends on slt_pkg, slt_scan and slt_queue.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid, in_stall  | ch
//   output   | out_valid, out_stall| token_kind, start_offset, token_length,
//            |                     | line_number, error_code, last_of_run
//
// One byte is taken per valid cycle unless in_stall; its tokens (zero to three) land
// in the queue at the same edge and leave in order, one per cycle unless out_stall.
// in_stall rises while the queue has fewer than three free entries, so the
// input rate drops below one byte a cycle only when tokens pile up.
// Reset starts a fresh source: offset 0, line 1, scanner idle, queue empty.
`default_nettype none

module script_lexer_tokenizer
    import slt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             ch,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [KIND_W-1:0]           token_kind,
    output logic [OFFSET_BITS-1:0]      start_offset,
    output logic [OFFSET_BITS-1:0]      token_length,
    output logic [LINE_BITS-1:0]        line_number,
    output logic [ERR_W-1:0]            error_code,
    output logic                        last_of_run
);

    localparam int TOK_W = KIND_W + 2*OFFSET_BITS + LINE_BITS + ERR_W + 1;
    localparam int LVL_W = $clog2(Q_DEPTH+1);

    logic                     in_accept;
    logic                     pop;
    kind_t                    tok_kind  [MAX_TOK];
    logic [OFFSET_BITS-1:0]   tok_start [MAX_TOK];
    logic [OFFSET_BITS-1:0]   tok_len   [MAX_TOK];
    err_t                     tok_err   [MAX_TOK];
    logic [LINE_BITS-1:0]     tok_line;
    logic [CNT_W-1:0]         tok_count;
    logic [CNT_W-1:0]         push_count;
    logic [TOK_W-1:0]         push_data [MAX_TOK];
    logic [TOK_W-1:0]         head;
    logic [LVL_W-1:0]         level;

    assign in_stall  = (level > LVL_W'(Q_DEPTH - MAX_TOK));
    assign in_accept = in_valid && !in_stall;

    slt_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .ch        (ch),
        .tok_kind  (tok_kind),
        .tok_start (tok_start),
        .tok_len   (tok_len),
        .tok_err   (tok_err),
        .tok_line  (tok_line),
        .tok_count (tok_count)
    );

    always_comb
    begin
        push_count = in_accept ? tok_count : '0;
        for (int i = 0; i < MAX_TOK; i++)
            push_data[i] = {tok_kind[i], tok_start[i], tok_len[i], tok_line, tok_err[i],
                            (CNT_W'(i + 1) == tok_count)};
    end

    slt_queue #(
        .W     (TOK_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .level      (level)
    );

    assign out_valid = (level != '0);
    assign pop       = out_valid && !out_stall;
    assign {token_kind, start_offset, token_length, line_number, error_code, last_of_run}
        = head;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LVL_W'(Q_DEPTH))
        else $error("token queue overfilled");

    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EOF |-> token_length == '0 && last_of_run)
        else $error("eof token malformed");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (error_code != ERR_NONE) == (token_kind == K_ERROR))
        else $error("error code disagrees with token kind");

    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !in_accept |=> level == $past(level) - 1'b1)
        else $error("queue level did not drop after pop");
`endif

endmodule

`default_nettype wire
